>>> sv/icdf_pkg.sv
`default_nettype none
package icdf_pkg;

    localparam int DEF_TABLE_DEPTH   = 4096;
    localparam int DEF_FRACTION_BITS = 32;

    localparam int IDX_W    = 12;
    localparam int CDF_W    = 33;
    localparam int ENERGY_W = 44;
    localparam int RND_W    = 32;
    // wide enough to hold any table depth in range for bound checks
    localparam int IDX_CMP_W = 17;

    localparam logic [IDX_W-1:0] LAST_INDEX_RESET = 12'd4000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_RDHI,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_MID,
        RD_LO,
        RD_HI
    } t_rd_sel;

    typedef struct packed {
        logic    wr;
        logic    start;
        t_rd_sel rd_sel;
        logic    cmp;
        logic    cap_lo;
        logic    prep;
        logic    div_step;
        logic    mul_step;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic need_div;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> sv/icdf_ctrl.sv
`default_nettype none
module icdf_ctrl
    import icdf_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_kind,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam int CW = $clog2(FRACTION_BITS);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.rd_sel = RD_LO;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_kind) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_PROBE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_PROBE: begin
                if (i_sts.more) begin
                    o_cmd.rd_sel = RD_MID;
                    n_state      = ST_CMP;
                end else begin
                    o_cmd.rd_sel = RD_LO;
                    n_state      = ST_RDHI;
                end
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_PROBE;
            end
            ST_RDHI: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_sel = RD_HI;
                n_state      = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = CW'(FRACTION_BITS - 1);
                n_state    = i_sts.need_div ? ST_DIV : ST_MUL;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = CW'(FRACTION_BITS - 1);
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_OUT: begin
                // wait until the previous beat has left the output register
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/icdf_dp.sv
`default_nettype none
module icdf_dp
    import icdf_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                i_clk,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic [IDX_W-1:0]    i_entry_index,
    input  wire logic [CDF_W-1:0]    i_cdf_value,
    input  wire logic [ENERGY_W-1:0] i_energy_value,
    input  wire logic [RND_W-1:0]    i_random_fraction,
    input  wire logic [IDX_W-1:0]    i_last_index,
    output logic [ENERGY_W-1:0]      o_energy,
    output logic [IDX_W-1:0]         o_lower_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FB = FRACTION_BITS;
    localparam logic [IDX_CMP_W-1:0] DEPTH_C = IDX_CMP_W'(TABLE_DEPTH);

    logic [CDF_W-1:0]    r_cdf_mem [TABLE_DEPTH];
    logic [ENERGY_W-1:0] r_eng_mem [TABLE_DEPTH];

    logic [CDF_W-1:0]    r_cdf_rd, r_clo, r_rem, r_den;
    logic [ENERGY_W-1:0] r_eng_rd, r_elo, r_ediff, r_acc;
    logic [ENERGY_W-1:0] r_energy;
    logic [IDX_W-1:0]    r_lower;
    logic [RND_W-1:0]    r_rnd;
    logic [AW-1:0]       r_lo, r_hi;
    logic [FB-1:0]       r_f;
    logic                r_full, r_neg;

    logic [AW:0]         idx_sum;
    logic [AW-1:0]       mid, rd_addr, top, wr_addr;
    logic                wr_en;
    logic [CDF_W-1:0]    rnd_x, num, den;
    logic                cdf_gt, rnd_le, num_ge;
    logic [CDF_W:0]      div_t;
    logic                div_ge;
    logic [ENERGY_W:0]   mul_sum;
    logic [ENERGY_W-1:0] step;

    assign idx_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = idx_sum[AW:1];
    assign top     = (IDX_CMP_W'(i_last_index) >= DEPTH_C) ? AW'(TABLE_DEPTH - 1)
                                                            : AW'(i_last_index);
    assign wr_en   = i_cmd.wr && (IDX_CMP_W'(i_entry_index) < DEPTH_C);
    assign wr_addr = AW'(i_entry_index);

    assign o_sts.more = (r_hi - r_lo) > AW'(1);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_MID:  rd_addr = mid;
            RD_LO:   rd_addr = r_lo;
            RD_HI:   rd_addr = r_hi;
            default: rd_addr = r_lo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cdf_mem[wr_addr] <= i_cdf_value;
            r_eng_mem[wr_addr] <= i_energy_value;
        end
        r_cdf_rd <= r_cdf_mem[rd_addr];
        r_eng_rd <= r_eng_mem[rd_addr];
    end

    // r_cdf_rd holds cdf[hi] and r_clo holds cdf[lo] during prep
    assign rnd_x    = {1'b0, r_rnd};
    assign num      = rnd_x - r_clo;
    assign den      = r_cdf_rd - r_clo;
    assign cdf_gt   = r_cdf_rd > r_clo;
    assign rnd_le   = rnd_x <= r_clo;
    assign num_ge   = num >= den;
    assign o_sts.need_div = cdf_gt && !rnd_le && !num_ge;

    // restoring division, one quotient bit per cycle
    assign div_t  = {r_rem, 1'b0};
    assign div_ge = div_t >= {1'b0, r_den};

    // shift-add multiply, LSB of the fraction first; dropped bits only floor
    assign mul_sum = {1'b0, r_acc} + (r_f[0] ? {1'b0, r_ediff} : '0);

    assign step = r_full ? r_ediff : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rnd <= i_random_fraction;
            r_lo  <= '0;
            r_hi  <= top;
        end
        if (i_cmd.cmp) begin
            if (r_cdf_rd <= rnd_x) begin
                r_lo <= mid;
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.cap_lo) begin
            r_clo <= r_cdf_rd;
            r_elo <= r_eng_rd;
        end
        if (i_cmd.prep) begin
            r_rem <= num;
            r_den <= den;
            r_acc <= '0;
            if (r_eng_rd >= r_elo) begin
                r_ediff <= r_eng_rd - r_elo;
                r_neg   <= 1'b0;
            end else begin
                r_ediff <= r_elo - r_eng_rd;
                r_neg   <= 1'b1;
            end
            if (!cdf_gt) begin
                // flat pair: halfway
                r_f    <= FB'(1) << (FB - 1);
                r_full <= 1'b0;
            end else if (rnd_le) begin
                r_f    <= '0;
                r_full <= 1'b0;
            end else if (num_ge) begin
                r_f    <= '0;
                r_full <= 1'b1;
            end else begin
                r_f    <= '0;
                r_full <= 1'b0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? CDF_W'(div_t - {1'b0, r_den}) : div_t[CDF_W-1:0];
            r_f   <= {r_f[FB-2:0], div_ge};
        end
        if (i_cmd.mul_step) begin
            r_acc <= mul_sum[ENERGY_W:1];
            r_f   <= r_f >> 1;
        end
        if (i_cmd.out_load) begin
            r_energy <= r_neg ? (r_elo - step) : (r_elo + step);
            r_lower  <= IDX_W'(r_lo);
        end
    end

    assign o_energy      = r_energy;
    assign o_lower_index = r_lower;

endmodule
`default_nettype wire

>>> sv/inverse_cdf_table_sampler_top.sv
// Inverse-transform sampler over a loaded cumulative distribution table.
// Input channel (i_in_valid / o_in_ready): kind 0 writes cdf_value and
// energy_value at entry_index (ignored beyond the table); kind 1 draws one
// sample for random_fraction. Output channel (o_out_valid / i_out_ready)
// carries one beat per sample: interpolated energy and lower table index.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes last_index,
// the top of the search range; write it only while the block is idle.
// A load beat is written while the block stays idle, so the input stays open.
// A sample runs P binary-search probes, P being about log2(last_index); each
// probe is a registered table read plus a compare. Then the upper entry is
// read and the divider is prepared; the restoring divider yields FRACTION_BITS
// quotient bits, skipped on a flat pair or a fraction clamped to zero or one,
// and the shift-add multiplier takes FRACTION_BITS fraction bits. The result
// is then loaded into the output register; o_out_valid rises and the input
// opens in the same cycle.
// One item is in work at a time. A result sits in the output register while
// the next items are accepted; a sample that finishes while the receiver
// still stalls the previous beat waits until that beat is taken.
// Reset clears control state and sets last_index to 4000; table contents are
// undefined until loaded.
`default_nettype none
module inverse_cdf_table_sampler_top
    import icdf_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_kind,
    input  wire logic [IDX_W-1:0]    i_entry_index,
    input  wire logic [CDF_W-1:0]    i_cdf_value,
    input  wire logic [ENERGY_W-1:0] i_energy_value,
    input  wire logic [RND_W-1:0]    i_random_fraction,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [ENERGY_W-1:0]      o_energy,
    output logic [IDX_W-1:0]         o_lower_index,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [IDX_W-1:0]    i_cfg_data
);

    logic [IDX_W-1:0] r_last_index;
    t_dp_cmd          cmd;
    t_dp_sts          sts;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_index <= LAST_INDEX_RESET;
        end else if (i_cfg_valid) begin
            r_last_index <= i_cfg_data;
        end
    end

    icdf_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    icdf_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_entry_index    (i_entry_index),
        .i_cdf_value      (i_cdf_value),
        .i_energy_value   (i_energy_value),
        .i_random_fraction(i_random_fraction),
        .i_last_index     (r_last_index),
        .o_energy         (o_energy),
        .o_lower_index    (o_lower_index)
    );

`ifndef SYNTHESIS
    // table writes happen only on an accepted load beat
    a_wr_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr |-> (i_in_valid && o_in_ready && !i_kind))
        else $error("table write without a load beat");

    // an accepted sample beat closes the input
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind) |=> !o_in_ready)
        else $error("input open during a sample");

    // the output register is reloaded only once its beat has gone
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

>>> tb/sv/icdf_tb_pkg.sv
package icdf_tb_pkg;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Q1.32 "one", the largest legal cdf entry
    localparam logic [32:0] CDF_ONE = 33'h1_0000_0000;

endpackage

>>> tb/sv/icdf_checker.sv
module icdf_checker
    import icdf_pkg::*;
    import icdf_tb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_kind,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [CDF_W-1:0]    i_cdf_value,
    input  logic [ENERGY_W-1:0] i_energy_value,
    input  logic [RND_W-1:0]    i_random_fraction,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [ENERGY_W-1:0] i_energy,
    input  logic [IDX_W-1:0]    i_lower_index,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int FB    = DEF_FRACTION_BITS;
    localparam int DIV_W = CDF_W + FB;
    localparam int MUL_W = CDF_W + ENERGY_W;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [IDX_W-1:0]    lower_index;
    } t_draw;

    logic [CDF_W-1:0]    cdf_tab    [DEPTH];
    logic [ENERGY_W-1:0] energy_tab [DEPTH];
    logic [IDX_W-1:0]    last_idx;
    t_draw               expected_draws [$];
    int                  errs = 0;

    // binary search for the bracketing pair, then linear interpolation
    function automatic t_draw predict_draw(input logic [RND_W-1:0] rnd);
        int                  lo, hi, mid, top;
        logic [CDF_W-1:0]    clo, chi, r33, frac;
        logic [ENERGY_W-1:0] elo, ehi, diff, delta;
        logic [DIV_W-1:0]    num;
        logic [MUL_W-1:0]    prod;
        t_draw               d;
        top = int'(last_idx);
        if (top > DEPTH - 1) top = DEPTH - 1;
        lo = 0;
        hi = top;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (cdf_tab[mid] <= {1'b0, rnd}) lo = mid;
            else hi = mid;
        end
        clo = cdf_tab[lo];
        chi = cdf_tab[hi];
        elo = energy_tab[lo];
        ehi = energy_tab[hi];
        r33 = {1'b0, rnd};
        if (chi > clo) begin
            if (r33 <= clo) begin
                frac = '0;
            end else if (r33 - clo >= chi - clo) begin
                frac = CDF_ONE;
            end else begin
                num  = DIV_W'(r33 - clo) << FB;
                frac = CDF_W'(num / DIV_W'(chi - clo));
            end
        end else begin
            // flat pair: halfway
            frac = CDF_ONE >> 1;
        end
        diff  = (ehi >= elo) ? ehi - elo : elo - ehi;
        prod  = MUL_W'(frac) * MUL_W'(diff);
        delta = ENERGY_W'(prod >> FB);
        d.energy      = (ehi >= elo) ? elo + delta : elo - delta;
        d.lower_index = IDX_W'(lo);
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_draw got, want;
        if (!i_rst_n) begin
            last_idx = LAST_INDEX_RESET;
            expected_draws.delete();
        end else begin
            // results first: a beat out can never belong to a beat in at the same edge
            if (i_out_valid && i_out_ready) begin
                got.energy      = i_energy;
                got.lower_index = i_lower_index;
                if (expected_draws.size() == 0) begin
                    $error("result beat with no sample pending: energy %h lower_index %0d",
                           got.energy, got.lower_index);
                    errs++;
                end else begin
                    want = expected_draws.pop_front();
                    if (got.energy !== want.energy) begin
                        $error("energy: expected %h, actual %h", want.energy, got.energy);
                        errs++;
                    end
                    if (got.lower_index !== want.lower_index) begin
                        $error("lower_index: expected %0d, actual %0d",
                               want.lower_index, got.lower_index);
                        errs++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) last_idx = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_LOAD) begin
                    if (int'(i_entry_index) < DEPTH) begin
                        cdf_tab[i_entry_index]    = i_cdf_value;
                        energy_tab[i_entry_index] = i_energy_value;
                    end
                end else begin
                    expected_draws.push_back(predict_draw(i_random_fraction));
                end
            end
        end
        o_fail_count <= errs;
        o_pending    <= expected_draws.size();
    end

endmodule

>>> tb/sv/tb_inverse_cdf_table_sampler_top.sv
module tb_inverse_cdf_table_sampler_top;
    import icdf_pkg::*;
    import icdf_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = DEF_TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int PHASE_ITEMS    = 195;
    localparam longint unsigned ENERGY_MAX = 64'h0000_0FFF_FFFF_FFFF;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_ready;
    logic                i_kind            = KIND_LOAD;
    logic [IDX_W-1:0]    i_entry_index     = '0;
    logic [CDF_W-1:0]    i_cdf_value       = '0;
    logic [ENERGY_W-1:0] i_energy_value    = '0;
    logic [RND_W-1:0]    i_random_fraction = '0;
    logic                o_out_valid;
    logic                i_out_ready       = 1'b0;
    logic [ENERGY_W-1:0] o_energy;
    logic [IDX_W-1:0]    o_lower_index;
    logic                i_cfg_valid       = 1'b0;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_data        = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int tx_idle_pct  = 27;
    int rx_idle_pct  = 48;
    int top_sh       = int'(LAST_INDEX_RESET);

    // what the table holds as far as the stimulus knows; keeps samples off unwritten entries
    logic [CDF_W-1:0] table_cdf     [DEPTH];
    bit               table_written [DEPTH];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    inverse_cdf_table_sampler_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_entry_index     (i_entry_index),
        .i_cdf_value       (i_cdf_value),
        .i_energy_value    (i_energy_value),
        .i_random_fraction (i_random_fraction),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_energy          (o_energy),
        .o_lower_index     (o_lower_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    icdf_checker u_icdf_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_entry_index     (i_entry_index),
        .i_cdf_value       (i_cdf_value),
        .i_energy_value    (i_energy_value),
        .i_random_fraction (i_random_fraction),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_energy          (o_energy),
        .i_lower_index     (o_lower_index),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [CDF_W-1:0] cdf, input logic [ENERGY_W-1:0] en,
                             input logic [RND_W-1:0] rnd);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= kind;
        i_entry_index     <= idx;
        i_cdf_value       <= cdf;
        i_energy_value    <= en;
        i_random_fraction <= rnd;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == KIND_LOAD) begin
            table_cdf[idx]     = cdf;
            table_written[idx] = 1'b1;
        end
        items_sent++;
        if (items_sent < 700) begin
            tx_idle_pct = 27;
            rx_idle_pct = 48;
        end else if (items_sent < 1400) begin
            tx_idle_pct = 48;
            rx_idle_pct = 27;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // hold off until every sample has come back, then let a trailing load finish
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_last_index(input int value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= IDX_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        top_sh = value;
    endtask

    // first entry the search for r would read that was never loaded, or -1
    function automatic int first_unwritten(input logic [RND_W-1:0] r);
        int lo, hi, mid;
        lo = 0;
        hi = top_sh;
        if (!table_written[lo]) return lo;
        if (!table_written[hi]) return hi;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (!table_written[mid]) return mid;
            if (table_cdf[mid] <= {1'b0, r}) lo = mid;
            else hi = mid;
        end
        return -1;
    endfunction

    // increasing cdf over 0..last_index, with jitter and the odd flat pair
    function automatic logic [CDF_W-1:0] fill_cdf(input int i);
        longint unsigned stp, base;
        int              span, k;
        span = (top_sh == 0) ? 1 : top_sh;
        stp  = 64'h1_0000_0000 / span;
        k    = ($urandom_range(7) == 0) ? (i & ~1) : i;
        base = longint'(k) * stp + $urandom_range(32'(stp / 2));
        if (base > CDF_ONE) base = CDF_ONE;
        return CDF_W'(base);
    endfunction

    function automatic logic [ENERGY_W-1:0] fill_energy(input int i);
        int span;
        span = (top_sh == 0) ? 1 : top_sh;
        if ($urandom_range(9) == 0) return {12'($urandom()), 32'($urandom())};
        return ENERGY_W'(longint'(i) * (ENERGY_MAX / span));
    endfunction

    function automatic logic [RND_W-1:0] pick_fraction();
        int idx;
        case ($urandom_range(19))
            0: return '0;
            1: return '1;
            2, 3: begin
                idx = $urandom_range(top_sh);
                if (table_written[idx] && table_cdf[idx] < CDF_ONE)
                    return table_cdf[idx][RND_W-1:0];
                return $urandom();
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic draw_sample(input logic [RND_W-1:0] r);
        int k;
        k = first_unwritten(r);
        while (k >= 0) begin
            send_beat(KIND_LOAD, IDX_W'(k), fill_cdf(k), fill_energy(k), $urandom());
            k = first_unwritten(r);
        end
        send_beat(KIND_SAMPLE, IDX_W'($urandom()), CDF_W'({$urandom(), $urandom()}),
                  ENERGY_W'({$urandom(), $urandom()}), r);
    endtask

    task automatic random_item();
        int               pick, idx;
        logic [CDF_W-1:0] cdf;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // unordered noise anywhere in the table
            cdf = ($urandom_range(15) == 0) ? CDF_ONE : CDF_W'($urandom());
            send_beat(KIND_LOAD, IDX_W'($urandom()), cdf,
                      {12'($urandom()), 32'($urandom())}, $urandom());
        end else if (pick < 28) begin
            idx = $urandom_range(top_sh);
            send_beat(KIND_LOAD, IDX_W'(idx), fill_cdf(idx), fill_energy(idx), $urandom());
        end else begin
            draw_sample(pick_fraction());
        end
    endtask

    initial begin
        int phase_tops [10];
        int start;
        bit paused_once;
        phase_tops  = '{4095, 1, 31, 2, 4000, 63, 3, 1000, 4095, 15};
        paused_once = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // small hand-built table
        set_last_index(7);
        send_beat(KIND_LOAD, 12'd0, 33'h0_1000_0000, 44'd0, '0);
        send_beat(KIND_LOAD, 12'd1, 33'h0_4000_0000, 44'd1000, '0);
        send_beat(KIND_LOAD, 12'd2, 33'h0_4000_0000, 44'd2000, '0);
        send_beat(KIND_LOAD, 12'd3, 33'h0_8000_0000, 44'hFFF_FFFF_FFFF, '0);
        send_beat(KIND_LOAD, 12'd4, 33'h0_A000_0000, 44'h100_0000_0000, '0);
        send_beat(KIND_LOAD, 12'd5, 33'h0_C000_0000, 44'h200_0000_0000, '0);
        send_beat(KIND_LOAD, 12'd6, 33'h0_F000_0000, 44'h300_0000_0000, '0);
        send_beat(KIND_LOAD, 12'd7, CDF_ONE, 44'hABC_DEF0_1234, '0);
        draw_sample(32'h0000_0000);   // below the first entry
        draw_sample(32'hFFFF_FFFF);   // last pair, top entry at one
        draw_sample(32'h4000_0000);
        draw_sample(32'h9000_0000);   // energy falls across the pair
        draw_sample(32'h2000_0000);
        send_beat(KIND_LOAD, 12'd7, 33'h0_F800_0000, 44'hABC_DEF0_1234, '0);
        draw_sample(32'hFFFF_FFFF);   // above the last entry
        send_beat(KIND_LOAD, 12'd7, 33'h0_F000_0000, 44'h555_5555_5555, '0);
        draw_sample(32'hF400_0000);   // flat last pair
        set_last_index(1);
        draw_sample(32'h3000_0000);
        draw_sample(32'h0800_0000);
        set_last_index(0);            // degenerate search, entry 0 only
        draw_sample(32'h5555_5555);

        foreach (phase_tops[p]) begin
            set_last_index(phase_tops[p]);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if (p == 3 && !paused_once && items_sent - start >= PHASE_ITEMS / 2) begin
                    drain();
                    paused_once = 1'b1;
                end
                random_item();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
sv/icdf_pkg.sv
sv/icdf_ctrl.sv
sv/icdf_dp.sv
sv/inverse_cdf_table_sampler_top.sv
tb/sv/icdf_tb_pkg.sv
tb/sv/icdf_checker.sv
tb/sv/tb_inverse_cdf_table_sampler_top.sv
